// File: rtl/sbfd_pkg.sv
// sbfd_pkg: shared types and constants for the frame decoder
// holds frame geometry, result status codes, register indexes and the
// front-to-back command and store write structures; no dependencies
package sbfd_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int FRAME_BYTES  = 25;

    localparam int BYTE_W   = 8;
    localparam int CH_W     = 11;
    localparam int CH_IDX_W = 4;
    localparam int POS_W    = 5;
    localparam int HELD_W   = 4;
    localparam int ACC_W    = 16;
    localparam int FLAG_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [POS_W-1:0] PAYLOAD_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] PAYLOAD_LAST  = POS_W'(FRAME_BYTES - 3);
    localparam logic [POS_W-1:0] FLAG_POS      = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] END_POS       = POS_W'(FRAME_BYTES - 1);

    localparam logic [CH_IDX_W-1:0] LAST_CH  = CH_IDX_W'(NUM_CHANNELS - 1);
    localparam logic [POS_W-1:0]    NUM_CH_W = POS_W'(NUM_CHANNELS);

    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'd1;

    localparam logic [BYTE_W-1:0] START_RESET = 8'h0f;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'h00;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_BAD_END   = 2'd2,
        ST_SHORT     = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [FLAG_W-1:0]   flags;
    } t_cmd;

    typedef struct packed {
        logic                we;
        logic [CH_IDX_W-1:0] idx;
        logic [CH_W-1:0]     data;
    } t_store_wr;

endpackage

// File: rtl/sbfd_fifo.sv
// sbfd_fifo: two-entry command queue between front and back
// depends on sbfd_pkg for the command type
module sbfd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbfd_pkg::t_cmd i_data,
    input  logic          i_pop,
    output sbfd_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);
    import sbfd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

// File: rtl/sbfd_front.sv
// sbfd_front: byte intake, frame tracking, bit unpacking and classification
// depends on sbfd_pkg; writes the channel store in sbfd_back, pushes sbfd_fifo
module sbfd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sbfd_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_frame_first,
    input  logic                          i_cfg_valid,
    input  logic [sbfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbfd_pkg::BYTE_W-1:0]   i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output sbfd_pkg::t_cmd                o_q_data,
    output sbfd_pkg::t_store_wr           o_store_wr,
    input  logic                          i_emit_done
);
    import sbfd_pkg::*;

    logic [BYTE_W-1:0] r_start_val;
    logic [BYTE_W-1:0] r_end_val;
    logic              r_in_frame;
    logic              r_start_ok;
    logic [POS_W-1:0]  r_pos;
    logic [ACC_W-1:0]  r_acc;
    logic [HELD_W-1:0] r_held;
    logic [POS_W-1:0]  r_widx;
    logic [FLAG_W-1:0] r_flags;
    logic              r_emit_pend;

    logic              n_in_frame;
    logic              n_start_ok;
    logic [POS_W-1:0]  n_pos;
    logic [ACC_W-1:0]  n_acc;
    logic [HELD_W-1:0] n_held;
    logic [POS_W-1:0]  n_widx;
    logic [FLAG_W-1:0] n_flags;

    logic              take;
    logic              is_payload;
    logic [ACC_W+1:0]  acc_ext;
    logic [POS_W-1:0]  held_sum;
    t_cmd              cmd;
    t_store_wr         wr;
    logic              push;

    assign is_payload = r_in_frame && !i_frame_first
                        && (r_pos >= PAYLOAD_FIRST) && (r_pos <= PAYLOAD_LAST);
    assign o_in_ready = !i_q_full && !(r_emit_pend && is_payload);
    assign take       = i_in_valid && o_in_ready;

    assign acc_ext  = {2'b00, r_acc} | ((ACC_W+2)'(i_rx_byte) << r_held);
    assign held_sum = POS_W'(r_held) + POS_W'(BYTE_W);

    always_comb begin
        n_in_frame = r_in_frame;
        n_start_ok = r_start_ok;
        n_pos      = r_pos;
        n_acc      = r_acc;
        n_held     = r_held;
        n_widx     = r_widx;
        n_flags    = r_flags;
        push       = 1'b0;
        cmd.status = ST_SHORT;
        cmd.flags  = r_flags;
        wr.we      = 1'b0;
        wr.idx     = r_widx[CH_IDX_W-1:0];
        wr.data    = acc_ext[CH_W-1:0];
        if (take) begin
            if (i_frame_first) begin
                push       = r_in_frame;
                cmd.status = ST_SHORT;
                n_in_frame = 1'b1;
                n_start_ok = (i_rx_byte == r_start_val);
                n_pos      = PAYLOAD_FIRST;
                n_acc      = '0;
                n_held     = '0;
                n_widx     = '0;
                n_flags    = '0;
            end else if (r_in_frame) begin
                if (is_payload) begin
                    if (held_sum >= POS_W'(CH_W)) begin
                        if (r_widx < NUM_CH_W) begin
                            wr.we  = 1'b1;
                            n_widx = r_widx + POS_W'(1);
                        end
                        n_acc  = ACC_W'(acc_ext >> CH_W);
                        n_held = HELD_W'(held_sum - POS_W'(CH_W));
                    end else begin
                        n_acc  = acc_ext[ACC_W-1:0];
                        n_held = held_sum[HELD_W-1:0];
                    end
                end else if (r_pos == FLAG_POS) begin
                    n_flags = i_rx_byte[BYTE_W-1 -: FLAG_W];
                end else if (r_pos == END_POS) begin
                    push       = 1'b1;
                    n_in_frame = 1'b0;
                    if (!r_start_ok) begin
                        cmd.status = ST_BAD_START;
                    end else if (i_rx_byte != r_end_val) begin
                        cmd.status = ST_BAD_END;
                    end else begin
                        cmd.status = ST_OK;
                    end
                end
                if (r_pos < POS_W'(FRAME_BYTES)) begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_val <= START_RESET;
            r_end_val   <= END_RESET;
            r_in_frame  <= 1'b0;
            r_start_ok  <= 1'b0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_held      <= '0;
            r_widx      <= '0;
            r_flags     <= '0;
            r_emit_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_START: r_start_val <= i_cfg_data;
                    CFG_END:   r_end_val   <= i_cfg_data;
                    default:   r_start_val <= r_start_val;
                endcase
            end
            r_in_frame <= n_in_frame;
            r_start_ok <= n_start_ok;
            r_pos      <= n_pos;
            r_acc      <= n_acc;
            r_held     <= n_held;
            r_widx     <= n_widx;
            r_flags    <= n_flags;
            if (push && cmd.status == ST_OK) begin
                r_emit_pend <= 1'b1;
            end else if (i_emit_done) begin
                r_emit_pend <= 1'b0;
            end
        end
    end

    assign o_q_push   = push;
    assign o_q_data   = cmd;
    assign o_store_wr = wr;

    // store must not change while the back end still reads it
    a_no_write_while_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_emit_pend && wr.we))
        else $error("channel store written during emit");

    a_single_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && cmd.status == ST_OK) |-> !r_emit_pend)
        else $error("second emit queued while one pending");

    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx <= NUM_CH_W)
        else $error("channel write index overran");

endmodule

// File: rtl/sbfd_back.sv
// sbfd_back: channel store and result sequencer with registered output
// depends on sbfd_pkg; pops commands from sbfd_fifo, store written by sbfd_front
module sbfd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sbfd_pkg::t_store_wr             i_store_wr,
    input  sbfd_pkg::t_cmd                  i_q_data,
    input  logic                            i_q_empty,
    output logic                            o_q_pop,
    output logic                            o_emit_done,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic [sbfd_pkg::CH_IDX_W-1:0]   o_channel_index,
    output logic [sbfd_pkg::CH_W-1:0]       o_channel_value,
    output logic                            o_digital_ch17,
    output logic                            o_digital_ch18,
    output logic                            o_lost_frame_flag,
    output logic                            o_failsafe_flag,
    output logic                            o_last_of_run
);
    import sbfd_pkg::*;

    logic [CH_W-1:0]     r_store [NUM_CHANNELS];
    logic                r_active;
    logic [CH_IDX_W-1:0] r_cnt;
    logic [FLAG_W-1:0]   r_flags;
    logic                r_ov;
    t_status             r_status;
    logic [CH_IDX_W-1:0] r_idx;
    logic [CH_W-1:0]     r_val;
    logic [FLAG_W-1:0]   r_oflags;
    logic                r_last;

    logic                load;
    logic                pop;
    logic                done;

    assign load = !r_ov || i_out_ready;
    assign pop  = load && !r_active && !i_q_empty;
    assign done = load && ((r_active && r_cnt == LAST_CH)
                  || (pop && i_q_data.status == ST_OK && LAST_CH == '0));

    always_ff @(posedge i_clk) begin
        if (i_store_wr.we) begin
            r_store[i_store_wr.idx] <= i_store_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
        end else if (load) begin
            if (r_active) begin
                r_ov     <= 1'b1;
                r_status <= ST_OK;
                r_idx    <= r_cnt;
                r_val    <= r_store[r_cnt];
                r_oflags <= r_flags;
                r_last   <= (r_cnt == LAST_CH);
                r_active <= (r_cnt != LAST_CH);
                r_cnt    <= r_cnt + CH_IDX_W'(1);
            end else if (!i_q_empty) begin
                r_ov     <= 1'b1;
                r_status <= i_q_data.status;
                r_idx    <= '0;
                if (i_q_data.status == ST_OK) begin
                    r_val    <= r_store[0];
                    r_oflags <= i_q_data.flags;
                    r_flags  <= i_q_data.flags;
                    r_last   <= (LAST_CH == '0);
                    r_active <= (LAST_CH != '0);
                    r_cnt    <= CH_IDX_W'(1);
                end else begin
                    r_val    <= '0;
                    r_oflags <= '0;
                    r_last   <= 1'b1;
                end
            end else begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_q_pop           = pop;
    assign o_emit_done       = done;
    assign o_out_valid       = r_ov;
    assign o_status          = r_status;
    assign o_channel_index   = r_idx;
    assign o_channel_value   = r_val;
    assign o_digital_ch17    = r_oflags[3];
    assign o_digital_ch18    = r_oflags[2];
    assign o_lost_frame_flag = r_oflags[1];
    assign o_failsafe_flag   = r_oflags[0];
    assign o_last_of_run     = r_last;

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_status != ST_OK) |-> (r_last && r_val == '0 && r_oflags == '0
                                         && r_idx == '0))
        else $error("error result carries channel data");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !i_q_empty)
        else $error("pop from empty queue");

    a_no_pop_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !pop && r_cnt != '0)
        else $error("queue popped during channel run");

endmodule

// File: rtl/sbus_frame_decoder_unit.sv
// sbus_frame_decoder_unit: top level of the 16-channel serial frame decoder
// instantiates sbfd_front, sbfd_fifo and sbfd_back; depends on sbfd_pkg
//
//  channel  signals                                   direction
//  input    i_in_valid/o_in_ready, rx_byte, frame_first   in
//  result   o_out_valid/i_out_ready, status .. last_of_run out
//  config   i_cfg_valid/o_cfg_ready, cfg_index, cfg_data   in
//
// one byte per cycle is taken unless the queue is full or a payload stall holds;
// a good frame end gives 16 results, one per accepted cycle from the store read
// port, an error gives one result; a two-entry command queue lets bytes flow
// while results drain; payload bytes of the next frame stall until the channel
// run has read the store; reset is synchronous, active low; no clearing pass
module sbus_frame_decoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sbfd_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                            i_frame_first,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic [sbfd_pkg::CH_IDX_W-1:0]   o_channel_index,
    output logic [sbfd_pkg::CH_W-1:0]       o_channel_value,
    output logic                            o_digital_ch17,
    output logic                            o_digital_ch18,
    output logic                            o_lost_frame_flag,
    output logic                            o_failsafe_flag,
    output logic                            o_last_of_run,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sbfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbfd_pkg::BYTE_W-1:0]     i_cfg_data
);
    import sbfd_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    t_cmd      q_wdata;
    t_cmd      q_rdata;
    t_store_wr store_wr;
    logic      emit_done;

    assign o_cfg_ready = 1'b1;

    sbfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_frame_first(i_frame_first),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata),
        .o_store_wr   (store_wr),
        .i_emit_done  (emit_done)
    );

    sbfd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .i_pop  (q_pop),
        .o_data (q_rdata),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    sbfd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_store_wr       (store_wr),
        .i_q_data         (q_rdata),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .o_emit_done      (emit_done),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_channel_index  (o_channel_index),
        .o_channel_value  (o_channel_value),
        .o_digital_ch17   (o_digital_ch17),
        .o_digital_ch18   (o_digital_ch18),
        .o_lost_frame_flag(o_lost_frame_flag),
        .o_failsafe_flag  (o_failsafe_flag),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

// File: tb/sbfd_result_checker.sv
// sbfd_result_checker: watches the byte, result and register channels of the
// frame decoder, predicts every result in order and compares all its fields at once
// depends on sbfd_pkg; reports the mismatch count and the results still due
module sbfd_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [sbfd_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                            i_frame_first,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [1:0]                      i_status,
    input  logic [sbfd_pkg::CH_IDX_W-1:0]   i_channel_index,
    input  logic [sbfd_pkg::CH_W-1:0]       i_channel_value,
    input  logic                            i_digital_ch17,
    input  logic                            i_digital_ch18,
    input  logic                            i_lost_frame_flag,
    input  logic                            i_failsafe_flag,
    input  logic                            i_last_of_run,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [sbfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbfd_pkg::BYTE_W-1:0]     i_cfg_data,
    output int                              o_pending,
    output int                              o_mismatches
);
    import sbfd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // flags: ch17, ch18, frame lost, failsafe from msb down
    typedef struct packed {
        t_status             status;
        logic [CH_IDX_W-1:0] index;
        logic [CH_W-1:0]     value;
        logic [FLAG_W-1:0]   flags;
        logic                last;
    } t_result;

    logic [BYTE_W-1:0]   start_value;
    logic [BYTE_W-1:0]   end_value;
    logic [POS_W-1:0]    byte_pos;
    logic                in_frame;
    logic                start_ok;
    logic [ACC_W-1:0]    bit_acc;
    logic [HELD_W-1:0]   held_bits;
    logic [POS_W-1:0]    wr_idx;
    logic [CH_W-1:0]     channel_mem [NUM_CHANNELS];
    logic [FLAG_W-1:0]   flag_nibble;
    t_result             results_due [$];
    int                  mismatches = 0;

    function automatic t_result error_result(input t_status st);
        t_result r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected status %0d ch %0d value %0d flags %b last %b",
                     $time, what, want.status, want.index, want.value, want.flags,
                     want.last);
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: got      status %0d ch %0d value %0d flags %b last %b",
                     $time, what, got.status, got.index, got.value, got.flags, got.last);
    endtask

    // lsb-first bit packing of payload bytes into 11-bit channels
    task automatic unpack_byte(input logic [BYTE_W-1:0] b);
        logic [ACC_W+BYTE_W-1:0] acc;
        logic [HELD_W:0]         held;
        acc  = {{BYTE_W{1'b0}}, bit_acc} | ((ACC_W + BYTE_W)'(b) << held_bits);
        held = {1'b0, held_bits} + (HELD_W + 1)'(BYTE_W);
        if (held >= CH_W) begin
            if (wr_idx < NUM_CH_W) begin
                channel_mem[wr_idx[CH_IDX_W-1:0]] = acc[CH_W-1:0];
                wr_idx = wr_idx + 1'b1;
            end
            acc  = acc >> CH_W;
            held = held - (HELD_W + 1)'(CH_W);
        end
        bit_acc   = acc[ACC_W-1:0];
        held_bits = held[HELD_W-1:0];
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic first);
        t_result r;
        int      i;
        if (first) begin
            if (in_frame)
                results_due.push_back(error_result(ST_SHORT));
            in_frame    = 1'b1;
            start_ok    = (b == start_value);
            byte_pos    = PAYLOAD_FIRST;
            bit_acc     = '0;
            held_bits   = '0;
            wr_idx      = '0;
            flag_nibble = '0;
        end else if (in_frame) begin
            if (byte_pos >= PAYLOAD_FIRST && byte_pos <= PAYLOAD_LAST) begin
                unpack_byte(b);
            end else if (byte_pos == FLAG_POS) begin
                flag_nibble = b[BYTE_W-1:BYTE_W-FLAG_W];
            end else if (byte_pos == END_POS) begin
                if (!start_ok) begin
                    results_due.push_back(error_result(ST_BAD_START));
                end else if (b != end_value) begin
                    results_due.push_back(error_result(ST_BAD_END));
                end else begin
                    for (i = 0; i < NUM_CHANNELS; i++) begin
                        r.status = ST_OK;
                        r.index  = CH_IDX_W'(i);
                        r.value  = channel_mem[i];
                        r.flags  = flag_nibble;
                        r.last   = (i == NUM_CHANNELS - 1);
                        results_due.push_back(r);
                    end
                end
                in_frame = 1'b0;
            end
            if (byte_pos < FRAME_BYTES)
                byte_pos = byte_pos + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            start_value = START_RESET;
            end_value   = END_RESET;
            byte_pos    = '0;
            in_frame    = 1'b0;
            start_ok    = 1'b0;
            bit_acc     = '0;
            held_bits   = '0;
            wr_idx      = '0;
            flag_nibble = '0;
            results_due.delete();
        end else begin
            // results first: nothing taken at this edge can already be out
            if (i_out_valid && i_out_ready) begin
                got.status = t_status'(i_status);
                got.index  = i_channel_index;
                got.value  = i_channel_value;
                got.flags  = {i_digital_ch17, i_digital_ch18, i_lost_frame_flag,
                              i_failsafe_flag};
                got.last   = i_last_of_run;
                if (results_due.size() == 0) begin
                    note_mismatch("result with none due", '0, got);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want)
                        note_mismatch("wrong result", want, got);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_START)
                    start_value = i_cfg_data;
                else if (i_cfg_index == CFG_END)
                    end_value = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                decode_byte(i_rx_byte, i_frame_first);
        end
        o_pending    <= results_due.size();
        o_mismatches <= mismatches;
    end

endmodule

// File: tb/sbus_frame_decoder_unit_test.sv
// sbus_frame_decoder_unit_test: drives byte frames and register writes into the
// frame decoder with random idling on both sides and gives the verdict
// depends on sbfd_pkg, sbus_frame_decoder_unit and sbfd_result_checker
module sbus_frame_decoder_unit_test;
    import sbfd_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int PHASE_BYTES   = 40;

    typedef enum int {
        FR_GOOD,
        FR_BAD_START,
        FR_BAD_END,
        FR_BAD_BOTH,
        FR_SHORT,
        FR_NOISE
    } t_frame_kind;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  frame_first;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [CH_IDX_W-1:0]   channel_index;
    logic [CH_W-1:0]       channel_value;
    logic                  digital_ch17;
    logic                  digital_ch18;
    logic                  lost_frame_flag;
    logic                  failsafe_flag;
    logic                  last_of_run;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [BYTE_W-1:0]     cfg_data;
    int                    pending;
    int                    mismatches;

    int                    cycles       = 0;
    int                    bytes_sent   = 0;
    int                    stall_orders = 0;
    int                    stall_taken  = 0;
    bit                    burst        = 1'b0;
    logic [BYTE_W-1:0]     cur_start    = START_RESET;
    logic [BYTE_W-1:0]     cur_end      = END_RESET;

    sbus_frame_decoder_unit uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_rx_byte         (rx_byte),
        .i_frame_first     (frame_first),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (status),
        .o_channel_index   (channel_index),
        .o_channel_value   (channel_value),
        .o_digital_ch17    (digital_ch17),
        .o_digital_ch18    (digital_ch18),
        .o_lost_frame_flag (lost_frame_flag),
        .o_failsafe_flag   (failsafe_flag),
        .o_last_of_run     (last_of_run),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    sbfd_result_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_rx_byte         (rx_byte),
        .i_frame_first     (frame_first),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_status          (status),
        .i_channel_index   (channel_index),
        .i_channel_value   (channel_value),
        .i_digital_ch17    (digital_ch17),
        .i_digital_ch18    (digital_ch18),
        .i_lost_frame_flag (lost_frame_flag),
        .i_failsafe_flag   (failsafe_flag),
        .i_last_of_run     (last_of_run),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_pending         (pending),
        .o_mismatches      (mismatches)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return FR_GOOD;
        if (r < 70)
            return FR_BAD_START;
        if (r < 80)
            return FR_BAD_END;
        if (r < 85)
            return FR_BAD_BOTH;
        if (r < 95)
            return FR_SHORT;
        return FR_NOISE;
    endfunction

    initial begin : result_sink
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (stall_taken != stall_orders) begin
                stall_taken++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if ($urandom_range(0, 9) == 0) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(30, 120)) @(posedge clk);
            end else if ($urandom_range(0, 1) == 0) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first);
        int gap;
        gap = (burst || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_first <= first;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_START)
            cur_start = data;
        else
            cur_end = data;
    endtask

    task automatic send_frame(input t_frame_kind kind);
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] tail;
        logic [BYTE_W-1:0] fill;
        int                body;
        int                mode;
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 6))
                send_byte(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
            return;
        end
        head = (kind == FR_BAD_START || kind == FR_BAD_BOTH) ?
               cur_start ^ BYTE_W'($urandom_range(1, 255)) : cur_start;
        tail = (kind == FR_BAD_END || kind == FR_BAD_BOTH) ?
               cur_end ^ BYTE_W'($urandom_range(1, 255)) : cur_end;
        mode = $urandom_range(0, 7);
        fill = (mode == 0) ? 8'hff : 8'h00;
        body = (kind == FR_SHORT) ? $urandom_range(0, FRAME_BYTES - 2) : FRAME_BYTES - 2;
        send_byte(head, 1'b1);
        repeat (body)
            send_byte((mode < 2) ? fill : BYTE_W'($urandom), 1'b0);
        if (kind != FR_SHORT) begin
            send_byte(tail, 1'b0);
            // trailing bytes outside any frame
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(BYTE_W'($urandom), 1'b0);
        end
    endtask

    task automatic run_frames(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
            send_frame(pick_kind());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        frame_first = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_START;
        cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte, a cut-off frame, then a frame with every bit set
        send_byte(8'ha5, 1'b0);
        send_byte(cur_start, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(cur_start, 1'b1);
        repeat (FRAME_BYTES - 3) send_byte(8'hff, 1'b0);
        send_byte(8'hf0, 1'b0);
        send_byte(cur_end, 1'b0);
        run_frames(PHASE_BYTES);

        // long result hold while full frames keep coming
        in_valid <= 1'b0;
        burst = 1'b1;
        stall_orders++;
        @(posedge clk);
        while (stall_taken != stall_orders) @(posedge clk);
        repeat (3) send_frame(FR_GOOD);
        burst = 1'b0;
        drain();

        write_reg(CFG_START, 8'h00);
        write_reg(CFG_END, 8'hff);
        run_frames(PHASE_BYTES);
        drain();

        write_reg(CFG_START, 8'hff);
        write_reg(CFG_END, 8'h00);
        run_frames(PHASE_BYTES);
        drain();

        write_reg(CFG_START, BYTE_W'($urandom));
        write_reg(CFG_END, BYTE_W'($urandom));
        run_frames(PHASE_BYTES);
        drain();

        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/sbfd_pkg.sv
rtl/sbfd_fifo.sv
rtl/sbfd_front.sv
rtl/sbfd_back.sv
rtl/sbus_frame_decoder_unit.sv
tb/sbfd_result_checker.sv
tb/sbus_frame_decoder_unit_test.sv
